/* rtl/mfdl_pkg.sv */
// Shared constants, codes, state and command types for the multirate frame delay line.
// No dependencies.
`default_nettype none

package mfdl_pkg;

	localparam int RING_DEPTH = 4096;               // power of two
	localparam int AW         = $clog2(RING_DEPTH);
	localparam int MAX_FRAMES = 16;
	localparam int FW         = $clog2(MAX_FRAMES);
	localparam int CW         = $clog2(MAX_FRAMES + 1);
	localparam int MAX_READ   = 64;

	localparam int LENW = 13;       // block_length, read_offset, frame length
	localparam int RTW  = 16;       // Q4.12 rate
	localparam int SW   = 24;       // Q1.23 sample
	localparam int CNTW = 7;        // read_count
	localparam int PW   = AW + 16;  // Q12.16 position
	localparam int SZW  = AW + 16;  // length * rate, and sums of it
	localparam int DVW  = SZW + 16; // divider numerator
	localparam int DCW  = $clog2(DVW + 1);
	localparam int PRW  = SW + 18;  // interpolation product

	localparam logic [LENW-1:0] DEPTH_L  = LENW'(RING_DEPTH);
	localparam logic [RTW-1:0]  RATE_ONE = RTW'(4096);
	localparam logic [PW-1:0]   HALF_POS = PW'(32768);
	localparam logic [PRW-1:0]  ROUND_P  = PRW'(32768);

	typedef enum logic [1:0] {
		ACT_BEGIN  = 2'd0,
		ACT_SAMPLE = 2'd1,
		ACT_READ   = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		RES_OK   = 2'd0,
		RES_FULL = 2'd1,
		RES_BAD  = 2'd2
	} res_status_t;

	typedef enum logic [4:0] {
		S_INIT, S_CLEAR, S_IDLE,
		S_BW_SCAN, S_BW_LAST, S_BW_DECIDE, S_BW_SHIFT, S_BW_COMMIT,
		S_EMIT_OK, S_EMIT_FULL, S_EMIT_BAD,
		S_RD_CHECK, S_TOT_MUL, S_TOT_ACC, S_MOD_START, S_MOD_WAIT,
		S_WALK_MUL, S_WALK_CMP, S_DIV_START, S_DIV_WAIT,
		S_RD_A, S_CAP_A, S_CAP_B, S_INTERP,
		S_ADV_SUB, S_ADV_CMP, S_ADV_MUL, S_ADV_LOAD, S_RD_EMIT
	} ctrl_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLR_INIT, OP_CLR_STEP, OP_ACCEPT,
		OP_BW_SCAN, OP_BW_LAST, OP_BW_DECIDE, OP_BW_SHIFT, OP_BW_COMMIT,
		OP_EMIT_OK, OP_EMIT_FULL, OP_EMIT_BAD, OP_EMIT_RD,
		OP_TOT_ACC, OP_MOD_START, OP_MOD_DONE, OP_WALK,
		OP_DIV_START, OP_POS_ADD, OP_RD_A, OP_CAP_A, OP_CAP_B, OP_INTERP,
		OP_ADV_SUB, OP_ADV_NEXT, OP_ADV_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic bw_bad;
		logic scan_stop;
		logic bw_full;
		logic shift_done;
		logic rd_bad;
		logic tot_last;
		logic div_done;
		logic walk_hit;
		logic linear;
		logic adv_more;
		logic rd_last;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

/* rtl/multirate_frame_delay_line.sv */
// Multirate frame delay line, top level: controller plus datapath.
// Write-sample transactions are taken in idle without leaving it; begin-write scans, decides,
// shifts and commits. A read sums the frame headers, divides modulo the total and walks back,
// then per result the 44-step divide, a ring read (two if linear) and an advance per frame crossed.
// Reset and clear start a pass that zeroes the ring; input is stalled meanwhile.
// Depends on mfdl_pkg, mfdl_ctrl, mfdl_dpath.
`default_nettype none

module multirate_frame_delay_line import mfdl_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           action,
	input  wire logic [LENW-1:0]      block_length,
	input  wire logic [RTW-1:0]       rate,
	input  wire logic signed [SW-1:0] sample_in,
	input  wire logic [LENW-1:0]      read_offset,
	input  wire logic [CNTW-1:0]      read_count,
	input  wire logic                 interp_mode,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [SW-1:0]      sample_out,
	output logic [PW-1:0]             end_position,
	output logic                      last,
	output logic [1:0]                status
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	mfdl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	mfdl_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.action       (action),
		.block_length (block_length),
		.rate         (rate),
		.sample_in    (sample_in),
		.read_offset  (read_offset),
		.read_count   (read_count),
		.interp_mode  (interp_mode),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.sample_out   (sample_out),
		.end_position (end_position),
		.last         (last),
		.status       (status)
	);

endmodule

`default_nettype wire

/* rtl/mfdl_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mfdl_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/mfdl_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on mfdl_pkg.
`default_nettype none

module mfdl_div import mfdl_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [DVW-1:0] dividend,
	input  wire logic [SZW-1:0] divisor,
	output logic                busy,
	output logic      [DVW-1:0] quo,
	output logic      [SZW-1:0] rem
);

	logic           busy_q;
	logic [DCW-1:0] cnt_q;
	logic [DVW-1:0] num_q;
	logic [SZW-1:0] rem_q;
	logic [SZW-1:0] div_q;
	logic [SZW:0]   trial;
	logic           fits;

	assign trial = {rem_q, num_q[DVW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DCW'(DVW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DCW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DVW-2:0], fits};
			rem_q <= fits ? SZW'(trial - {1'b0, div_q}) : trial[SZW-1:0];
		end
	end

	assign busy = busy_q;
	assign quo  = num_q;
	assign rem  = rem_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

/* rtl/mfdl_dpath.sv */
// Datapath: frame header table, sample ring, position arithmetic, output register.
// Depends on mfdl_pkg, mfdl_ram and mfdl_div.
`default_nettype none

module mfdl_dpath import mfdl_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire dp_cmd_t                cmd,
	output dp_stat_t                    stat,
	input  wire logic [1:0]             action,
	input  wire logic [LENW-1:0]        block_length,
	input  wire logic [RTW-1:0]         rate,
	input  wire logic signed [SW-1:0]   sample_in,
	input  wire logic [LENW-1:0]        read_offset,
	input  wire logic [CNTW-1:0]        read_count,
	input  wire logic                   interp_mode,
	input  wire logic                   out_stall,
	output logic                        out_valid,
	output logic signed [SW-1:0]        sample_out,
	output logic [PW-1:0]               end_position,
	output logic                        last,
	output logic [1:0]                  status
);

	logic [AW-1:0]   fh_q [MAX_FRAMES];
	logic [LENW-1:0] fl_q [MAX_FRAMES];
	logic [AW-1:0]   ft_q [MAX_FRAMES];
	logic [RTW-1:0]  fr_q [MAX_FRAMES];
	logic [CW-1:0]   fc_q;
	logic [AW-1:0]   wp_q;
	logic [LENW-1:0] left_q;
	logic [LENW-1:0] pskip_q;
	logic [AW-1:0]   clr_cnt_q;

	logic [RTW-1:0]  rate_q;
	logic [LENW-1:0] off_q;
	logic [CNTW-1:0] cnt_q;
	logic            mode_q;
	logic [LENW-1:0] n_q;
	logic [LENW-1:0] bskip_q;

	logic [FW-1:0]   fidx_q;
	logic [CW-1:0]   k_q;
	logic [LENW-1:0] pre_q;
	logic            partial_q;
	logic [LENW-1:0] want_q;
	logic [AW-1:0]   nhead_q;
	logic [LENW-1:0] nlen_q;
	logic [CW-1:0]   cpp_q;

	logic [SZW-1:0]  size_q;
	logic [SZW-1:0]  tot_q;
	logic [SZW-1:0]  inframe_q;
	logic [SZW-1:0]  need_q;
	logic [PW-1:0]   pos_q;
	logic [SW-1:0]   a_q;
	logic [SW-1:0]   s_q;
	logic signed [PRW-1:0] prod_s1;

	logic            out_valid_q;
	logic [SW-1:0]   sample_q;
	logic [PW-1:0]   endpos_q;
	logic            last_q;
	logic [1:0]      status_q;

	logic [AW-1:0]   cur_head;
	logic [LENW-1:0] cur_len;
	logic [AW-1:0]   cur_tail;
	logic [RTW-1:0]  cur_rate;
	logic [LENW:0]   scan_sum;
	logic            scan_take;
	logic [CW-1:0]   cp;
	logic            merge;
	logic [CW-1:0]   cpp;
	logic [LENW+RTW-1:0] size_full;
	logic [LENW+RTW-1:0] need_full;
	logic [CW-1:0]   fc_m1;
	logic [CW-1:0]   fidx_p1;
	logic [PW-1:0]   pos_half;
	logic [AW-1:0]   near_idx;
	logic [AW-1:0]   near_p;
	logic [AW-1:0]   lin_idx;
	logic signed [SW:0] diff;
	logic [PRW-1:0]  interp_sum;
	logic            out_free;
	logic            accept;
	logic            smp_wr;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [SW-1:0]   ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [SW-1:0]   ram_rdata;

	logic            div_start;
	logic            div_sel_mod;
	logic [DVW-1:0]  div_num;
	logic [SZW-1:0]  div_den;
	logic            div_busy;
	logic [DVW-1:0]  div_quo;
	logic [SZW-1:0]  div_rem;

	assign cur_head  = fh_q[fidx_q];
	assign cur_len   = fl_q[fidx_q];
	assign cur_tail  = ft_q[fidx_q];
	assign cur_rate  = fr_q[fidx_q];

	assign scan_sum  = {1'b0, pre_q} + {1'b0, cur_len};
	assign scan_take = (k_q < fc_q) && (scan_sum <= {1'b0, n_q});
	assign cp        = fc_q - k_q;
	assign merge     = (cp > CW'(1)) && (cur_rate == rate_q);
	assign cpp       = cp - CW'(merge);

	assign size_full = cur_len * cur_rate;
	assign need_full = read_offset * rate;
	assign fc_m1     = fc_q - 1'b1;
	assign fidx_p1   = {1'b0, fidx_q} + 1'b1;

	assign pos_half  = pos_q + HALF_POS;
	assign near_idx  = pos_half[PW-1:16];
	assign near_p    = (near_idx != cur_tail) ? near_idx :
	                   (near_idx == '0) ? '0 : near_idx - 1'b1;
	assign lin_idx   = pos_q[PW-1:16];

	assign diff       = $signed({ram_rdata[SW-1], ram_rdata}) - $signed({a_q[SW-1], a_q});
	assign interp_sum = prod_s1 + ROUND_P;

	assign out_free  = !out_valid_q || !out_stall;
	assign accept    = cmd.op == OP_ACCEPT;
	assign smp_wr    = accept && (action == ACT_SAMPLE) && (pskip_q == '0) && (left_q != '0);

	assign ram_we    = (cmd.op == OP_CLR_STEP) || smp_wr;
	assign ram_waddr = (cmd.op == OP_CLR_STEP) ? clr_cnt_q : wp_q;
	assign ram_wdata = (cmd.op == OP_CLR_STEP) ? '0 : sample_in;
	assign ram_re    = (cmd.op == OP_RD_A) || ((cmd.op == OP_CAP_A) && mode_q);
	assign ram_raddr = (cmd.op == OP_CAP_A) ? lin_idx + 1'b1 :
	                   mode_q ? lin_idx : near_p;

	assign div_start   = (cmd.op == OP_MOD_START) || (cmd.op == OP_DIV_START);
	assign div_sel_mod = cmd.op == OP_MOD_START;
	assign div_num     = div_sel_mod ? DVW'(need_q - 1'b1) : {need_q, 16'b0};
	assign div_den     = div_sel_mod ? tot_q : SZW'(cur_rate);

	mfdl_ram #(
		.WIDTH(SW),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	mfdl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_ff @(posedge clk) begin
		size_q <= size_full[SZW-1:0];
		unique case (cmd.op)
			OP_CLR_INIT: begin
				fh_q[0]   <= '0;
				fl_q[0]   <= DEPTH_L;
				ft_q[0]   <= '0;
				fr_q[0]   <= RATE_ONE;
				fc_q      <= CW'(1);
				wp_q      <= '0;
				left_q    <= '0;
				pskip_q   <= '0;
				clr_cnt_q <= '0;
			end
			OP_CLR_STEP: begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			OP_ACCEPT: begin
				rate_q <= rate;
				off_q  <= read_offset;
				cnt_q  <= read_count;
				mode_q <= interp_mode;
				fidx_q <= '0;
				k_q    <= '0;
				pre_q  <= '0;
				tot_q  <= '0;
				need_q <= need_full[SZW-1:0];
				if (block_length > DEPTH_L) begin
					n_q     <= DEPTH_L;
					bskip_q <= block_length - DEPTH_L;
				end else begin
					n_q     <= block_length;
					bskip_q <= '0;
				end
				if (action == ACT_BEGIN) begin
					wp_q    <= wp_q + left_q[AW-1:0];
					left_q  <= '0;
					pskip_q <= '0;
				end else if (action == ACT_SAMPLE) begin
					if (pskip_q != '0) begin
						pskip_q <= pskip_q - 1'b1;
					end else if (left_q != '0) begin
						wp_q   <= wp_q + 1'b1;
						left_q <= left_q - 1'b1;
					end
				end
			end
			OP_BW_SCAN: begin
				if (scan_take) begin
					pre_q  <= scan_sum[LENW-1:0];
					k_q    <= k_q + 1'b1;
					fidx_q <= fidx_q + 1'b1;
				end
			end
			OP_BW_LAST: begin
				fidx_q <= fc_m1[FW-1:0];
			end
			OP_BW_DECIDE: begin
				cpp_q     <= cpp;
				partial_q <= (cp != '0) && (pre_q < n_q);
				want_q    <= n_q - pre_q;
				nhead_q   <= merge ? cur_head : wp_q;
				nlen_q    <= merge ? n_q + cur_len : n_q;
			end
			OP_BW_SHIFT: begin
				if (k_q != '0) begin
					for (int j = 0; j < MAX_FRAMES - 1; j++) begin
						fh_q[j] <= fh_q[j+1];
						fl_q[j] <= fl_q[j+1];
						ft_q[j] <= ft_q[j+1];
						fr_q[j] <= fr_q[j+1];
					end
					k_q <= k_q - 1'b1;
				end
			end
			OP_BW_COMMIT: begin
				if (partial_q) begin
					fh_q[0] <= fh_q[0] + want_q[AW-1:0];
					fl_q[0] <= fl_q[0] - want_q;
				end
				fh_q[cpp_q[FW-1:0]] <= nhead_q;
				fl_q[cpp_q[FW-1:0]] <= nlen_q;
				ft_q[cpp_q[FW-1:0]] <= nhead_q + nlen_q[AW-1:0];
				fr_q[cpp_q[FW-1:0]] <= rate_q;
				fc_q    <= cpp_q + 1'b1;
				left_q  <= n_q;
				pskip_q <= bskip_q;
			end
			OP_TOT_ACC: begin
				tot_q  <= tot_q + size_q;
				fidx_q <= fidx_q + 1'b1;
			end
			OP_MOD_DONE: begin
				need_q <= div_rem + 1'b1;
				fidx_q <= fc_m1[FW-1:0];
			end
			OP_WALK: begin
				if (need_q <= size_q) begin
					need_q    <= size_q - need_q;
					inframe_q <= size_q;
					pos_q     <= {cur_head, 16'b0};
				end else begin
					need_q <= need_q - size_q;
					fidx_q <= (fidx_q == '0) ? fc_m1[FW-1:0] : fidx_q - 1'b1;
				end
			end
			OP_POS_ADD: begin
				pos_q <= pos_q + div_quo[PW-1:0];
			end
			OP_CAP_A: begin
				a_q <= ram_rdata;
				s_q <= ram_rdata;
			end
			OP_CAP_B: begin
				prod_s1 <= $signed({1'b0, pos_q[15:0]}) * diff;
			end
			OP_INTERP: begin
				s_q <= a_q + interp_sum[SW+15:16];
			end
			OP_ADV_SUB: begin
				inframe_q <= inframe_q - need_q;
				need_q    <= SZW'(rate_q);
			end
			OP_ADV_NEXT: begin
				need_q <= need_q - inframe_q;
				fidx_q <= (fidx_p1 == fc_q) ? '0 : fidx_p1[FW-1:0];
			end
			OP_ADV_LOAD: begin
				inframe_q <= size_q;
				pos_q     <= {cur_head, 16'b0};
			end
			OP_EMIT_OK, OP_EMIT_FULL, OP_EMIT_BAD: begin
				sample_q <= '0;
				endpos_q <= '0;
				last_q   <= 1'b1;
				status_q <= (cmd.op == OP_EMIT_OK)   ? RES_OK :
				            (cmd.op == OP_EMIT_FULL) ? RES_FULL : RES_BAD;
			end
			OP_EMIT_RD: begin
				sample_q <= s_q;
				endpos_q <= (cnt_q == CNTW'(1)) ? pos_q : '0;
				last_q   <= cnt_q == CNTW'(1);
				status_q <= RES_OK;
				cnt_q    <= cnt_q - 1'b1;
			end
			OP_NONE, OP_MOD_START, OP_DIV_START, OP_RD_A: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.op == OP_EMIT_OK) || (cmd.op == OP_EMIT_FULL) ||
		             (cmd.op == OP_EMIT_BAD) || (cmd.op == OP_EMIT_RD)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		stat.clr_last   = &clr_cnt_q;
		stat.bw_bad     = (n_q == '0) || (rate_q == '0);
		stat.scan_stop  = !scan_take;
		stat.bw_full    = cpp >= CW'(MAX_FRAMES);
		stat.shift_done = k_q == '0;
		stat.rd_bad     = (rate_q == '0) || (off_q == '0) || (off_q > DEPTH_L) ||
		                  (cnt_q == '0) || (cnt_q > CNTW'(MAX_READ));
		stat.tot_last   = {1'b0, fidx_q} == fc_m1;
		stat.div_done   = !div_busy;
		stat.walk_hit   = need_q <= size_q;
		stat.linear     = mode_q;
		stat.adv_more   = inframe_q < need_q;
		stat.rd_last    = cnt_q == CNTW'(1);
		stat.out_free   = out_free;
	end

	assign out_valid    = out_valid_q;
	assign sample_out   = sample_q;
	assign end_position = endpos_q;
	assign last         = last_q;
	assign status       = status_q;

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.op == OP_EMIT_OK) || (cmd.op == OP_EMIT_FULL) ||
		 (cmd.op == OP_EMIT_BAD) || (cmd.op == OP_EMIT_RD)) |-> out_free)
		else $error("result loaded over a pending transaction");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_BW_COMMIT) |=> ((fc_q != '0) && (fc_q <= CW'(MAX_FRAMES))))
		else $error("frame count out of range after commit");
`endif

endmodule

`default_nettype wire

/* rtl/mfdl_ctrl.sv */
// Controller state machine: sequences clear, begin-write, sample-write and read.
// Depends on mfdl_pkg.
`default_nettype none

module mfdl_ctrl import mfdl_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] action,
	input  wire dp_stat_t   stat,
	output logic            in_stall,
	output dp_cmd_t         cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT:  state_d = S_CLEAR;
			S_CLEAR: if (stat.clr_last) state_d = S_IDLE;
			S_IDLE: begin
				if (in_valid) begin
					unique case (action_t'(action))
						ACT_BEGIN:  state_d = S_BW_SCAN;
						ACT_SAMPLE: state_d = S_IDLE;
						ACT_READ:   state_d = S_RD_CHECK;
						ACT_CLEAR:  state_d = S_INIT;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_BW_SCAN: begin
				if (stat.bw_bad) state_d = S_EMIT_BAD;
				else if (stat.scan_stop) state_d = S_BW_LAST;
			end
			S_BW_LAST:   state_d = S_BW_DECIDE;
			S_BW_DECIDE: state_d = stat.bw_full ? S_EMIT_FULL : S_BW_SHIFT;
			S_BW_SHIFT:  if (stat.shift_done) state_d = S_BW_COMMIT;
			S_BW_COMMIT: state_d = S_EMIT_OK;
			S_EMIT_OK, S_EMIT_FULL, S_EMIT_BAD: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			S_RD_CHECK:  state_d = stat.rd_bad ? S_EMIT_BAD : S_TOT_MUL;
			S_TOT_MUL:   state_d = S_TOT_ACC;
			S_TOT_ACC:   state_d = stat.tot_last ? S_MOD_START : S_TOT_MUL;
			S_MOD_START: state_d = S_MOD_WAIT;
			S_MOD_WAIT:  if (stat.div_done) state_d = S_WALK_MUL;
			S_WALK_MUL:  state_d = S_WALK_CMP;
			S_WALK_CMP:  state_d = stat.walk_hit ? S_DIV_START : S_WALK_MUL;
			S_DIV_START: state_d = S_DIV_WAIT;
			S_DIV_WAIT:  if (stat.div_done) state_d = S_RD_A;
			S_RD_A:      state_d = S_CAP_A;
			S_CAP_A:     state_d = stat.linear ? S_CAP_B : S_ADV_SUB;
			S_CAP_B:     state_d = S_INTERP;
			S_INTERP:    state_d = S_ADV_SUB;
			S_ADV_SUB:   state_d = S_ADV_CMP;
			S_ADV_CMP:   state_d = stat.adv_more ? S_ADV_MUL : S_RD_EMIT;
			S_ADV_MUL:   state_d = S_ADV_LOAD;
			S_ADV_LOAD:  state_d = S_ADV_CMP;
			S_RD_EMIT: begin
				if (stat.out_free) state_d = stat.rd_last ? S_IDLE : S_DIV_START;
			end
			default: state_d = S_INIT;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		in_stall = state_q != S_IDLE;
		unique case (state_q)
			S_INIT:      cmd.op = OP_CLR_INIT;
			S_CLEAR:     cmd.op = OP_CLR_STEP;
			S_IDLE:      if (in_valid) cmd.op = OP_ACCEPT;
			S_BW_SCAN:   if (!stat.bw_bad) cmd.op = OP_BW_SCAN;
			S_BW_LAST:   cmd.op = OP_BW_LAST;
			S_BW_DECIDE: cmd.op = OP_BW_DECIDE;
			S_BW_SHIFT:  cmd.op = OP_BW_SHIFT;
			S_BW_COMMIT: cmd.op = OP_BW_COMMIT;
			S_EMIT_OK:   if (stat.out_free) cmd.op = OP_EMIT_OK;
			S_EMIT_FULL: if (stat.out_free) cmd.op = OP_EMIT_FULL;
			S_EMIT_BAD:  if (stat.out_free) cmd.op = OP_EMIT_BAD;
			S_TOT_ACC:   cmd.op = OP_TOT_ACC;
			S_MOD_START: cmd.op = OP_MOD_START;
			S_MOD_WAIT:  if (stat.div_done) cmd.op = OP_MOD_DONE;
			S_WALK_CMP:  cmd.op = OP_WALK;
			S_DIV_START: cmd.op = OP_DIV_START;
			S_DIV_WAIT:  if (stat.div_done) cmd.op = OP_POS_ADD;
			S_RD_A:      cmd.op = OP_RD_A;
			S_CAP_A:     cmd.op = OP_CAP_A;
			S_CAP_B:     cmd.op = OP_CAP_B;
			S_INTERP:    cmd.op = OP_INTERP;
			S_ADV_SUB:   cmd.op = OP_ADV_SUB;
			S_ADV_CMP:   if (stat.adv_more) cmd.op = OP_ADV_NEXT;
			S_ADV_LOAD:  cmd.op = OP_ADV_LOAD;
			S_RD_EMIT:   if (stat.out_free) cmd.op = OP_EMIT_RD;
			S_RD_CHECK, S_TOT_MUL, S_WALK_MUL, S_ADV_MUL: cmd.op = OP_NONE;
			default:     cmd.op = OP_NONE;
		endcase
	end

`ifndef SYNTHESIS
	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DIV_WAIT) && !stat.div_done) |=> (state_q == S_DIV_WAIT))
		else $error("left divide wait before quotient ready");
`endif

endmodule

`default_nettype wire

/* tb/multirate_frame_delay_line_test.sv */
// Self-checking testbench for multirate_frame_delay_line: bursty driver, stalling monitor,
// and an in-bench predictor of the frame table, sample ring and interpolating reader.
// Depends on mfdl_pkg and the multirate_frame_delay_line RTL.
`timescale 1ns / 1ps

module multirate_frame_delay_line_test;
	import mfdl_pkg::*;

	typedef struct {
		action_t                act;
		logic [LENW-1:0]        blen;
		logic [RTW-1:0]         rt;
		logic signed [SW-1:0]   smp;
		logic [LENW-1:0]        off;
		logic [CNTW-1:0]        cnt;
		logic                   mode;
	} dl_item_t;

	typedef struct {
		logic signed [SW-1:0] smp;
		logic [PW-1:0]        pos;
		logic                 lst;
		logic [1:0]           st;
	} dl_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] action = '0;
	logic [LENW-1:0] block_length = '0;
	logic [RTW-1:0] rate = '0;
	logic signed [SW-1:0] sample_in = '0;
	logic [LENW-1:0] read_offset = '0;
	logic [CNTW-1:0] read_count = '0;
	logic interp_mode = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [SW-1:0] sample_out;
	logic [PW-1:0] end_position;
	logic last;
	logic [1:0] status;

	multirate_frame_delay_line dut (.*);

	always #4 clk = ~clk;

	dl_item_t   pending_items[$];
	dl_result_t expected_results[$];
	dl_item_t   cur;
	int mismatches = 0;
	int burst_left = 4, gap_left = 0;

	// mirrored block state
	logic signed [SW-1:0] ring[RING_DEPTH];
	int unsigned fhead[MAX_FRAMES], flen[MAX_FRAMES], ftail[MAX_FRAMES], frate[MAX_FRAMES];
	int unsigned fcount, wptr, open_left, open_skip;

	function automatic void expect_result(logic signed [SW-1:0] s, longint unsigned p,
			bit l, res_status_t st);
		dl_result_t r;
		r.smp = s; r.pos = p[PW-1:0]; r.lst = l; r.st = st;
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic void clear_line();
		foreach (ring[i]) ring[i] = '0;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			fhead[i] = 0; flen[i] = 0; ftail[i] = 0; frate[i] = 0;
		end
		flen[0] = RING_DEPTH; frate[0] = 4096;
		fcount = 1; wptr = 0; open_left = 0; open_skip = 0;
	endfunction

	function automatic res_status_t claim_block(int unsigned n, int unsigned rt);
		int unsigned h[MAX_FRAMES], l[MAX_FRAMES], t[MAX_FRAMES], r[MAX_FRAMES];
		int unsigned c, done, skip, want, len, head;
		c = fcount; done = 0; skip = 0;
		if (open_left > 0) wptr = (wptr + open_left) % RING_DEPTH;
		open_left = 0; open_skip = 0;
		if (n == 0 || rt == 0) return RES_BAD;
		if (n > RING_DEPTH) begin
			skip = n - RING_DEPTH; n = RING_DEPTH;
		end
		h = fhead; l = flen; t = ftail; r = frate;
		while (done < n && c > 0) begin
			want = n - done;
			if (l[0] <= want) begin
				done += l[0];
				for (int i = 1; i < c; i++) begin
					h[i-1] = h[i]; l[i-1] = l[i]; t[i-1] = t[i]; r[i-1] = r[i];
				end
				c--;
			end else begin
				h[0] = (h[0] + want) % RING_DEPTH; l[0] -= want; done = n;
			end
		end
		len = n; head = wptr;
		if (c > 1 && r[c-1] == rt) begin
			len += l[c-1]; head = h[c-1]; c--;
		end
		if (c >= MAX_FRAMES) return RES_FULL;
		h[c] = head; l[c] = len; t[c] = (head + len) % RING_DEPTH; r[c] = rt;
		c++;
		fhead = h; flen = l; ftail = t; frate = r; fcount = c;
		open_left = n; open_skip = skip;
		return RES_OK;
	endfunction

	function automatic void predict_read(int unsigned off, int unsigned cnt, int unsigned rt,
			bit mode);
		longint need, tot, inframe;
		longint unsigned pos, dq;
		int unsigned idx, p;
		longint a, b, prod;
		logic signed [SW-1:0] s;
		dq = longint'(RING_DEPTH) << 16;
		tot = 0; inframe = 0;
		if (rt == 0 || off == 0 || off > RING_DEPTH || cnt == 0 || cnt > MAX_READ) begin
			expect_result('0, 0, 1'b1, RES_BAD);
			return;
		end
		for (int i = 0; i < fcount; i++) tot += longint'(flen[i]) * frate[i];
		need = longint'(off) * rt;
		if (need > tot) need -= ((need - 1) / tot) * tot;
		idx = fcount;
		while (need > 0) begin
			idx = (idx == 0) ? fcount - 1 : idx - 1;
			inframe = longint'(flen[idx]) * frate[idx];
			need -= inframe;
		end
		need = -need;
		pos = longint'(fhead[idx]) << 16;
		for (int i = 0; i < cnt; i++) begin
			pos += (longint'(need) << 16) / frate[idx];
			pos %= dq;
			if (mode) begin
				p = 32'(pos >> 16);
				a = ring[p % RING_DEPTH];
				b = ring[(p + 1) % RING_DEPTH];
				prod = longint'(pos & 64'hFFFF) * (b - a);
				s = SW'(a + ((prod + 32768) >>> 16));
			end else begin
				p = 32'(((pos + 64'h8000) >> 16) % RING_DEPTH);
				if (p == ftail[idx]) p = (p > 0) ? p - 1 : 0;
				s = ring[p];
			end
			inframe -= need;
			need = rt;
			while (inframe < need) begin
				need -= inframe;
				idx = (idx + 1) % fcount;
				inframe = longint'(flen[idx]) * frate[idx];
				pos = longint'(fhead[idx]) << 16;
			end
			expect_result(s, (i + 1 == cnt) ? pos : 0, i + 1 == cnt, RES_OK);
		end
	endfunction

	function automatic void predict_transaction(dl_item_t it);
		case (it.act)
			ACT_BEGIN: expect_result('0, 0, 1'b1, claim_block(it.blen, it.rt));
			ACT_SAMPLE: begin
				if (open_skip > 0) open_skip--;
				else if (open_left > 0) begin
					ring[wptr] = it.smp;
					wptr = (wptr + 1) % RING_DEPTH;
					open_left--;
				end
			end
			ACT_READ: predict_read(it.off, it.cnt, it.rt, it.mode);
			default: clear_line();
		endcase
	endfunction

	function automatic void queue_item(action_t act, int unsigned blen, int unsigned rt,
			int unsigned off, int unsigned cnt, int unsigned mode);
		dl_item_t it;
		it.act = act; it.blen = LENW'(blen); it.rt = RTW'(rt); it.smp = SW'($urandom);
		it.off = LENW'(off); it.cnt = CNTW'(cnt); it.mode = mode[0];
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic int unsigned pick_rate();
		case ($urandom_range(0, 4))
			0, 1: return 4096;
			2: return 2048;
			3: return 6144;
			default: return $urandom_range(1, 65535);
		endcase
	endfunction

	// driver: bursts with random gaps, holds payload while stalled
	always @(posedge clk or negedge arst_n) begin
		dl_item_t it;
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && !in_stall) predict_transaction(cur);
			if (in_valid && in_stall) begin
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 0;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				cur = it;
				action <= it.act; block_length <= it.blen; rate <= it.rt;
				sample_in <= it.smp; read_offset <= it.off; read_count <= it.cnt;
				interp_mode <= it.mode;
				in_valid <= 1;
				if (--burst_left <= 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 0;
			end
		end
	end

	// long receiver hold-off window, counted in cycles after reset
	int unsigned hold_cnt = 0;
	logic long_hold = 0;
	always @(posedge clk) begin
		if (arst_n) hold_cnt <= hold_cnt + 1;
		long_hold <= (hold_cnt >= 5000) && (hold_cnt < 7000);
	end

	// receiver stall pattern
	int unsigned rx_cycle = 0;
	always @(posedge clk) begin
		rx_cycle++;
		if (long_hold) out_stall <= 1;
		else if ((rx_cycle / 2000) % 3 == 0) out_stall <= 0;
		else out_stall <= ($urandom_range(0, 3) == 0);
	end

	// monitor
	always @(posedge clk) begin
		dl_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result: sample %0d", sample_out);
			end else begin
				e = expected_results.pop_front();
				if (sample_out !== e.smp || end_position !== e.pos || last !== e.lst ||
						status !== e.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp s=%0d p=%0h l=%0b st=%0d got s=%0d p=%0h l=%0b st=%0d",
							e.smp, e.pos, e.lst, e.st, sample_out, end_position, last, status);
				end
			end
		end
	end

	initial begin
		int n, blen, rt, sel;
		clear_line();
		// directed
		queue_item(ACT_READ, 0, 4096, 1, 1, 0);
		queue_item(ACT_SAMPLE, 0, 0, 0, 0, 0);
		queue_item(ACT_BEGIN, 0, 4096, 0, 0, 0);
		queue_item(ACT_BEGIN, 5, 0, 0, 0, 0);
		queue_item(ACT_BEGIN, 8, 4096, 0, 0, 0);
		for (int i = 0; i < 8; i++) queue_item(ACT_SAMPLE, 0, 0, 0, 0, 0);
		queue_item(ACT_BEGIN, 4097, 65535, 0, 0, 0);
		for (int i = 0; i < 3; i++) queue_item(ACT_SAMPLE, 0, 0, 0, 0, 0);
		queue_item(ACT_READ, 0, 4096, 4, 4, 0);
		queue_item(ACT_READ, 0, 2048, 10, 4, 1);
		queue_item(ACT_READ, 0, 65535, 4096, 64, 1);
		queue_item(ACT_READ, 0, 0, 1, 1, 0);
		queue_item(ACT_READ, 0, 4096, 0, 1, 0);
		queue_item(ACT_READ, 0, 4096, 8191, 1, 0);
		queue_item(ACT_READ, 0, 4096, 1, 0, 0);
		queue_item(ACT_READ, 0, 4096, 1, 127, 1);
		for (int i = 0; i < 17; i++) queue_item(ACT_BEGIN, 1, 4096 + (i % 2), 0, 0, 0);
		queue_item(ACT_READ, 0, 1, 3, 2, 1);
		queue_item(ACT_CLEAR, 0, 0, 0, 0, 0);
		queue_item(ACT_READ, 0, 4096, 2, 2, 1);
		// random
		n = 0;
		while (n < 275) begin
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				blen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 24);
				queue_item(ACT_BEGIN, blen, pick_rate(), $urandom, $urandom, $urandom);
				if ($urandom_range(0, 7) == 0) blen = $urandom_range(0, blen);
				for (int i = 0; i < blen; i++) queue_item(ACT_SAMPLE, $urandom, $urandom,
					$urandom, $urandom, $urandom);
				n += 1 + blen;
			end else if (sel < 85) begin
				rt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : pick_rate();
				queue_item(ACT_READ, $urandom, rt, $urandom_range(1, RING_DEPTH),
					($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8),
					$urandom);
				n++;
			end else if (sel < 89) begin
				queue_item(ACT_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom);
				n++;
			end else if (sel < 93) begin
				queue_item(ACT_BEGIN, $urandom, $urandom, $urandom, $urandom, $urandom);
				n++;
			end else if (sel < 98) begin
				queue_item(ACT_READ, $urandom, $urandom, $urandom, $urandom, $urandom);
				n++;
			end else begin
				queue_item(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
				n++;
			end
		end
		repeat (7) @(posedge clk);
		arst_n <= 1;
		do @(posedge clk); while (pending_items.size() > 0 || in_valid);
		do @(posedge clk); while (expected_results.size() > 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	initial begin
		#60ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
